>>> src/csce_pkg.sv
// Package for the symbol checksum encoder: item types, op codes and the
// polymod generator constants. Used by every module of the block.
package csce_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_PREFIX = 2'd0,
        OP_SEP    = 2'd1,
        OP_BYTE   = 2'd2,
        OP_FINISH = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic [4:0] symbol;
        logic       is_check;
        logic       last;
    } t_out_item;

    localparam int CHK_W = 40;
    localparam int SYM_W = 5;

    // Polymod generator terms, one per bit of the top symbol
    localparam logic [CHK_W-1:0] GEN [SYM_W] = '{
        40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4,
        40'hae2eabe2a8, 40'h1e4f43e470
    };

    localparam logic [CHK_W-1:0] CHK_RESET = 40'h1;

    // Finish sequence: step 0 pads leftover bits, 1..8 fold zeros,
    // 9..16 emit the checksum symbols
    localparam logic [4:0] FIN_FOLD_LAST = 5'd8;
    localparam logic [4:0] FIN_EMIT_FIRST = 5'd9;
    localparam logic [4:0] FIN_LAST = 5'd16;

endpackage

>>> src/csce_fold.sv
// One polymod fold step: shift in a 5-bit symbol, reduce by the generator.
// Depends on csce_pkg.
module csce_fold
    import csce_pkg::*;
(
    input  logic [CHK_W-1:0] i_check,
    input  logic [SYM_W-1:0] i_sym,
    output logic [CHK_W-1:0] o_check
);

    logic [SYM_W-1:0] w_top;

    assign w_top = i_check[CHK_W-1 -: SYM_W];

    // Shift the low 35 bits up and xor in a generator term per top bit
    always_comb begin
        o_check = {i_check[CHK_W-SYM_W-1:0], i_sym};
        for (int j = 0; j < SYM_W; j++) begin
            if (w_top[j]) begin
                o_check = o_check ^ GEN[j];
            end
        end
    end

endmodule

>>> src/csce_out_reg.sv
// Output result register with valid/ready toward the consumer.
// Depends on csce_pkg.
module csce_out_reg
    import csce_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_item,
    output logic      o_can_load,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_vld;
    t_out_item r_item;

    // Register may take a new result when empty or being drained
    assign o_can_load  = !r_vld || i_out_ready;
    assign o_out_valid = r_vld;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load && o_can_load) begin
            r_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_item <= i_item;
        end
    end

endmodule

>>> src/cashaddr_symbol_checksum_encoder_unit.sv
// Symbol checksum encoder top level: input register, step sequencer, fold unit.
// Results are registered and offered in the cycle after their step; items pass the
// input register first. Prefix chars and separators take a single step, bytes one
// per symbol, a finish pad, fold and emit steps; an emitting step waits while the
// output register is full. Reset (synchronous, active low): checksum = 1, no
// leftover bits, both channels empty. Depends on csce_pkg, csce_fold, csce_out_reg.
module cashaddr_symbol_checksum_encoder_unit
    import csce_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // Block state
    logic [CHK_W-1:0] r_check;
    logic [3:0]       r_lo_bits;
    logic [2:0]       r_lo_cnt;

    // Item in work
    logic             r_item_vld;
    t_in_item         r_item;
    logic [4:0]       r_step;

    logic             w_fold_en;
    logic [SYM_W-1:0] w_fold_sym;
    logic [CHK_W-1:0] w_fold_out;
    logic             w_emit;
    logic             w_last_step;
    t_out_item        w_out;
    logic             w_can_load;
    logic             w_adv;
    logic             w_done;

    logic [2:0]       w_cnt;
    logic [11:0]      w_acc;
    logic [3:0]       w_bits;
    logic             w_two;
    logic [3:0]       w_sh;
    logic [11:0]      w_mask;
    logic [SYM_W-1:0] w_pad_sym;
    logic [CHK_W-1:0] w_fin;
    logic [2:0]       w_idx;
    logic [5:0]       w_base;

    csce_fold u_fold (
        .i_check (r_check),
        .i_sym   (w_fold_sym),
        .o_check (w_fold_out)
    );

    csce_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_adv && w_emit),
        .i_item      (w_out),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Regrouping of a payload byte with the leftover bits
    assign w_cnt  = (r_lo_cnt > 3'd4) ? 3'd4 : r_lo_cnt;
    assign w_acc  = {r_lo_bits, r_item.data_value};
    assign w_bits = 4'(w_cnt) + 4'd8;
    assign w_two  = (w_cnt >= 3'd2);
    assign w_sh   = r_step[0] ? (w_bits - 4'd10) : (w_bits - 4'd5);
    assign w_mask = (12'd1 << w_sh) - 12'd1;

    // Zero-padded leftover symbol for finish
    assign w_pad_sym = 5'({5'd0, r_lo_bits} << (3'd5 - w_cnt));

    // Checksum symbol select, most significant first
    assign w_fin  = r_check ^ CHK_RESET;
    assign w_idx  = 3'(r_step - FIN_EMIT_FIRST);
    assign w_base = 6'd35 - ({1'b0, w_idx, 2'b00} + {3'd0, w_idx});

    // Step decode
    always_comb begin
        w_fold_en   = 1'b0;
        w_fold_sym  = '0;
        w_emit      = 1'b0;
        w_last_step = 1'b0;
        w_out       = '0;
        unique case (r_item.op)
            OP_PREFIX: begin
                w_fold_en   = 1'b1;
                w_fold_sym  = r_item.data_value[SYM_W-1:0];
                w_last_step = 1'b1;
            end
            OP_SEP: begin
                w_fold_en   = 1'b1;
                w_last_step = 1'b1;
            end
            OP_BYTE: begin
                w_fold_en    = 1'b1;
                w_emit       = 1'b1;
                w_fold_sym   = 5'(w_acc >> w_sh);
                w_out.symbol = w_fold_sym;
                w_last_step  = r_step[0] || !w_two;
            end
            OP_FINISH: begin
                if (r_step == 5'd0) begin
                    w_fold_en    = (w_cnt != 3'd0);
                    w_emit       = (w_cnt != 3'd0);
                    w_fold_sym   = w_pad_sym;
                    w_out.symbol = w_pad_sym;
                end else if (r_step <= FIN_FOLD_LAST) begin
                    w_fold_en = 1'b1;
                end else begin
                    w_emit         = 1'b1;
                    w_out.symbol   = w_fin[w_base +: SYM_W];
                    w_out.is_check = 1'b1;
                    w_out.last     = (r_step == FIN_LAST);
                    w_last_step    = (r_step == FIN_LAST);
                end
            end
            default: begin
                w_last_step = 1'b1;
            end
        endcase
    end

    // A step runs unless it must emit and the output register is full and not draining
    assign w_adv      = r_item_vld && (!w_emit || w_can_load);
    assign w_done     = w_adv && w_last_step;
    assign o_in_ready = !r_item_vld || w_done;

    // Input register and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_step     <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_item_vld <= 1'b1;
            end else if (w_done) begin
                r_item_vld <= 1'b0;
            end
            if (w_adv) begin
                r_step <= w_last_step ? 5'd0 : (r_step + 5'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_item;
        end
    end

    // Checksum and leftover bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check   <= CHK_RESET;
            r_lo_bits <= '0;
            r_lo_cnt  <= '0;
        end else if (w_adv) begin
            if (w_fold_en) begin
                r_check <= w_fold_out;
            end
            if (w_last_step && r_item.op == OP_BYTE) begin
                r_lo_bits <= 4'(w_acc & w_mask);
                r_lo_cnt  <= 3'(w_sh);
            end
            if (w_last_step && r_item.op == OP_FINISH) begin
                r_check   <= CHK_RESET;
                r_lo_bits <= '0;
                r_lo_cnt  <= '0;
            end
        end
    end

    // Leftover count never goes past four bits
    a_lo_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo_cnt <= 3'd4)
        else $error("leftover count out of range");

    // A byte takes at most two steps
    a_byte_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_vld && r_item.op == OP_BYTE) |-> (r_step <= 5'd1))
        else $error("byte step overflow");

    // Finish leaves the block in its reset state
    a_fin_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && r_item.op == OP_FINISH) |=>
            (r_check == CHK_RESET && r_lo_cnt == 3'd0))
        else $error("state not cleared after finish");

    // Idle input stage always takes a transfer
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_item_vld |-> o_in_ready)
        else $error("idle but not ready");

    // Only a checksum symbol may be marked last
    a_last_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit && w_out.last) |-> w_out.is_check)
        else $error("last on a payload symbol");

endmodule
